>>> hdl/dst_pkg.sv
// Shared constants and types for the dual sample timer block.
package dst_pkg;

	// Timer geometry.
	localparam int A_BITS  = 10;
	localparam int B_SHIFT = 4;
	localparam int B_BITS  = 8 + B_SHIFT;
	// Working width for timer A writes: wide enough for both the counter and the
	// ten bits that the two address registers can reach.
	localparam int A_EXT   = (A_BITS > 10) ? A_BITS : 10;

	// Register addresses.
	localparam logic [7:0] REG_TA_LO = 8'h24;
	localparam logic [7:0] REG_TA_HI = 8'h25;
	localparam logic [7:0] REG_TB    = 8'h26;
	localparam logic [7:0] REG_CTRL  = 8'h27;

	// Bit positions in the control register.
	localparam int CTRL_LOAD_A  = 0;
	localparam int CTRL_LOAD_B  = 1;
	localparam int CTRL_EN_A    = 2;
	localparam int CTRL_EN_B    = 3;
	localparam int CTRL_CLR_A   = 4;
	localparam int CTRL_CLR_B   = 5;

	// Item kinds.
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} dst_op_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] status_flags;
		logic       irq_a;
		logic       irq_b;
	} dst_rsp_t;

endpackage

>>> hdl/dst_if.sv
// Handshake channels for the dual sample timer: command in, status out.
interface dst_cmd_if;
	import dst_pkg::*;
	logic       valid;
	logic       ready;
	dst_op_t    op;
	logic [7:0] reg_addr;
	logic [7:0] write_data;

	modport source (output valid, output op, output reg_addr, output write_data, input ready);
	modport sink   (input valid, input op, input reg_addr, input write_data, output ready);
endinterface

interface dst_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status_flags;
	logic       irq_a;
	logic       irq_b;

	modport source (output valid, output status_flags, output irq_a, output irq_b, input ready);
	modport sink   (input valid, input status_flags, input irq_a, input irq_b, output ready);
endinterface

>>> hdl/dual_sample_timer_with_flags.sv
// Top level of the dual sample timer with overflow flags.
//
//   channel | dir | payload                          | one beat is
//   --------+-----+----------------------------------+------------------------------
//   cmd     | in  | op, reg_addr[7:0], write_data[7:0] | a register write or one tick
//   rsp     | out | status_flags[1:0], irq_a, irq_b  | the status after that item
//
// The timer state updates at the edge that accepts a cmd beat; the status lands at
// that edge in the output register, or in the skid entry if the output is held.
// Reset (arst_n low) clears counters, load/enable bits, flags and both output stages.
// A beat may follow every cycle, as a two-entry output (register plus skid) keeps
// cmd.ready high while one result waits; cmd.ready drops only once the skid is full.
module dual_sample_timer_with_flags (
	input  logic       clk,
	input  logic       arst_n,
	dst_cmd_if.sink    cmd,
	dst_rsp_if.source  rsp
);
	import dst_pkg::*;

	// Timer state.
	logic [A_BITS-1:0] count_a_q;
	logic [B_BITS-1:0] count_b_q;
	logic              load_a_q;
	logic              load_b_q;
	logic              enable_a_q;
	logic              enable_b_q;
	logic [1:0]        flags_q;

	// Next-state values for the accepted beat.
	logic [A_BITS-1:0] count_a_d;
	logic [B_BITS-1:0] count_b_d;
	logic              load_a_d;
	logic              load_b_d;
	logic              enable_a_d;
	logic              enable_b_d;
	logic [1:0]        flags_d;
	logic              pulse_a;
	logic              pulse_b;
	logic [A_EXT-1:0]  a_ext;
	logic [A_BITS-1:0] a_inc;
	logic [B_BITS-1:0] b_inc;

	// Output register and skid entry.
	dst_rsp_t out_q;
	dst_rsp_t skid_q;
	logic     out_valid_q;
	logic     skid_valid_q;
	dst_rsp_t rsp_new;

	logic cmd_fire;
	logic rsp_fire;

	assign cmd.ready = !skid_valid_q;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp_fire  = out_valid_q && rsp.ready;

	assign a_ext = A_EXT'(count_a_q);
	assign a_inc = count_a_q + A_BITS'(1);
	assign b_inc = count_b_q + B_BITS'(1);

	// Work out the effect of one item on the timer state.
	always_comb begin
		count_a_d  = count_a_q;
		count_b_d  = count_b_q;
		load_a_d   = load_a_q;
		load_b_d   = load_b_q;
		enable_a_d = enable_a_q;
		enable_b_d = enable_b_q;
		flags_d    = flags_q;
		pulse_a    = 1'b0;
		pulse_b    = 1'b0;
		unique case (cmd.op)
			OP_WRITE: begin
				unique case (cmd.reg_addr)
					REG_TA_LO: begin
						// Replace the low byte, keep everything above it.
						count_a_d = A_BITS'((a_ext & ~A_EXT'(8'hff)) | A_EXT'(cmd.write_data));
					end
					REG_TA_HI: begin
						// Keep the low byte; bits 9..8 from data, anything higher clears.
						count_a_d = A_BITS'((a_ext & A_EXT'(8'hff))
							| (A_EXT'(cmd.write_data[1:0]) << 8));
					end
					REG_TB: begin
						count_b_d = B_BITS'(cmd.write_data) << B_SHIFT;
					end
					REG_CTRL: begin
						load_a_d   = cmd.write_data[CTRL_LOAD_A];
						load_b_d   = cmd.write_data[CTRL_LOAD_B];
						enable_a_d = cmd.write_data[CTRL_EN_A];
						enable_b_d = cmd.write_data[CTRL_EN_B];
						if (cmd.write_data[CTRL_CLR_A]) begin
							flags_d[0] = 1'b0;
						end
						if (cmd.write_data[CTRL_CLR_B]) begin
							flags_d[1] = 1'b0;
						end
					end
					default: begin
						// Other addresses leave the timers alone.
					end
				endcase
			end
			OP_TICK: begin
				// Advance each loaded counter; raise its flag on a wrap to zero when enabled.
				if (load_a_q) begin
					count_a_d = a_inc;
					if (a_inc == '0 && enable_a_q && !flags_q[0]) begin
						flags_d[0] = 1'b1;
						pulse_a    = 1'b1;
					end
				end
				if (load_b_q) begin
					count_b_d = b_inc;
					if (b_inc == '0 && enable_b_q && !flags_q[1]) begin
						flags_d[1] = 1'b1;
						pulse_b    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_new = '{status_flags: flags_d, irq_a: pulse_a, irq_b: pulse_b};

	// Timer state: update on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			load_a_q   <= 1'b0;
			load_b_q   <= 1'b0;
			enable_a_q <= 1'b0;
			enable_b_q <= 1'b0;
			flags_q    <= '0;
		end else if (cmd_fire) begin
			count_a_q  <= count_a_d;
			count_b_q  <= count_b_d;
			load_a_q   <= load_a_d;
			load_b_q   <= load_b_d;
			enable_a_q <= enable_a_d;
			enable_b_q <= enable_b_d;
			flags_q    <= flags_d;
		end
	end

	// Output register with skid entry. A new result goes straight to the output
	// when it is free or draining this cycle, else it waits in the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// cmd.ready is low here, so only drain.
			if (rsp_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (cmd_fire) begin
			if (!out_valid_q || rsp_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (rsp_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the two output entries; no reset needed.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_fire) begin
				out_q <= skid_q;
			end
		end else if (cmd_fire) begin
			if (!out_valid_q || rsp_fire) begin
				out_q <= rsp_new;
			end else begin
				skid_q <= rsp_new;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status_flags = out_q.status_flags;
	assign rsp.irq_a        = out_q.irq_a;
	assign rsp.irq_b        = out_q.irq_b;

	// The skid entry only fills behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while output register empty");

	// A reported interrupt always comes with its flag set.
	a_irq_has_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.irq_a || out_q.irq_b) |->
		((!out_q.irq_a || out_q.status_flags[0]) && (!out_q.irq_b || out_q.status_flags[1])))
		else $error("interrupt pulse without its flag");

	// A register write never pulses an interrupt.
	a_write_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd.op == OP_WRITE |-> !pulse_a && !pulse_b)
		else $error("interrupt pulse on a register write");

	// Flag A only rises through a tick that pulses it.
	a_flag_a_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(flags_q[0]) && flags_q[0] |-> $past(cmd_fire && pulse_a))
		else $error("flag A set without an interrupt pulse");

endmodule
